>>> hw/rtl/scy_pkg.sv
// Shared constants, codes and types of the scytale transposition block.
package scy_pkg;

  localparam int MAX_LEN = 64;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int CW      = AW + 1;
  localparam int BUF_AW  = AW + 1;

  localparam int CHAR_W   = 8;
  localparam int RODS_W   = 7;
  localparam int CFG_IX_W = 2;

  localparam logic [CFG_IX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_RODS = 2'd1;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct packed {
    logic [CW-1:0]     n;
    logic              mode;
    logic [RODS_W-1:0] cols;
    logic              ovf;
    logic              bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [CHAR_W-1:0] data;
  } buf_wr_t;

endpackage

>>> hw/rtl/scy_in_if.sv
// Input byte channel.
interface scy_in_if;
  import scy_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

>>> hw/rtl/scy_out_if.sv
// Result character channel.
interface scy_out_if;
  import scy_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              empty_res;
  logic              overflow;
  modport source (output valid, output out_char, output out_last, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input out_char, input out_last, input empty_res,
                  input overflow, output ready);
endinterface

>>> hw/rtl/scy_cfg_if.sv
// Configuration write channel.
interface scy_cfg_if;
  import scy_pkg::*;
  logic                valid;
  logic                ready;
  logic [CFG_IX_W-1:0] index;
  logic [RODS_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/scy_front.sv
// Front end: configuration registers, byte filter and buffer loader.
module scy_front
  import scy_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  scy_in_if.sink         in_ch,
  scy_cfg_if.sink        cfg_ch,
  input  logic           hold,
  input  logic           job_full,
  output logic           job_push,
  output job_t           job,
  output buf_wr_t        buf_wr
);

  logic              mode_r, mode_nxt;
  logic [RODS_W-1:0] rods_r, rods_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              bank_r, bank_nxt;

  logic              accept;
  logic              keep;
  logic [CHAR_W-1:0] ch;
  logic              room;
  logic [CW-1:0]     cnt_inc;
  logic              ovf_inc;

  assign in_ch.ready  = !hold && !job_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    ch   = in_ch.in_char;
    keep = 1'b0;
    if (mode_r == MODE_ENC) begin
      if (in_ch.in_char >= 8'h61 && in_ch.in_char <= 8'h7a) begin
        ch   = in_ch.in_char - 8'd32;
        keep = 1'b1;
      end else begin
        keep = (in_ch.in_char >= 8'h41 && in_ch.in_char <= 8'h5a);
      end
    end else begin
      keep = (in_ch.in_char != '0);
    end
  end

  assign room    = (cnt_r < CW'(MAX_LEN));
  assign cnt_inc = (keep && room) ? cnt_r + CW'(1) : cnt_r;
  assign ovf_inc = ovf_r || (keep && !room);

  assign buf_wr.en   = accept && keep && room;
  assign buf_wr.addr = {bank_r, cnt_r[AW-1:0]};
  assign buf_wr.data = ch;

  assign job_push  = accept && in_ch.in_last;
  assign job.n     = cnt_inc;
  assign job.mode  = mode_r;
  assign job.cols  = (rods_r == '0) ? RODS_W'(1) : rods_r;
  assign job.ovf   = ovf_inc;
  assign job.bank  = bank_r;

  always_comb begin
    mode_nxt = mode_r;
    rods_nxt = rods_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MODE: mode_nxt = cfg_ch.data[0];
        CFG_RODS: rods_nxt = cfg_ch.data;
        default:  ;
      endcase
    end
    if (accept) begin
      if (in_ch.in_last) begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = !bank_r;
      end else begin
        cnt_nxt = cnt_inc;
        ovf_nxt = ovf_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      rods_r <= RODS_W'(1);
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      rods_r <= rods_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

>>> hw/rtl/scy_job_fifo.sv
// Two-entry queue of finished-message descriptors between front and back.
module scy_job_fifo
  import scy_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       head,
  output logic       not_empty,
  output logic       full,
  output logic [1:0] count
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign count     = cnt_r;
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hw/rtl/scy_back.sv
// Back end: text buffer and the sequencer that reads it out in transposed order.
module scy_back
  import scy_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  buf_wr_t  buf_wr,
  input  logic     job_valid,
  input  job_t     job_in,
  output logic     job_pop,
  output logic     busy,
  scy_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_RUN,
    ST_EMPTY
  } state_t;

  logic [CHAR_W-1:0] mem [2*MAX_LEN];

  state_t            state_r;
  job_t              job_r;
  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     rows_r;
  logic [CW:0]       idx_r;
  logic [RODS_W-1:0] col_r;
  logic [CW-1:0]     row_r;
  logic [CW-1:0]     sent_r;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              empty_r;
  logic              ovf_r;

  logic              out_free;
  logic              load_out;
  logic [CW:0]       enc_step;
  logic [CW:0]       dec_step;
  logic              is_final;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign load_out  = out_free && ((state_r == ST_RUN) || (state_r == ST_EMPTY));
  assign busy      = (state_r != ST_IDLE);
  assign job_pop   = (state_r == ST_IDLE) && job_valid;
  assign is_final  = ((sent_r + CW'(1)) == job_r.n);

  // Encrypt walks down a column; decrypt jumps to the same row of the next column.
  assign enc_step = idx_r + (CW+1)'(job_r.cols);
  assign dec_step = idx_r + (CW+1)'(rows_r) - (CW+1)'(1)
                    + (((CW+1)'(col_r) < (CW+1)'(rem_r)) ? (CW+1)'(1) : '0);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.empty_res = empty_r;
  assign out_ch.overflow  = ovf_r;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            job_r  <= job_in;
            rem_r  <= job_in.n;
            rows_r <= '0;
            idx_r  <= '0;
            col_r  <= '0;
            row_r  <= '0;
            sent_r <= '0;
            if (job_in.n == '0) begin
              state_r <= ST_EMPTY;
            end else if (job_in.mode == MODE_DEC) begin
              state_r <= ST_SPLIT;
            end else begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_SPLIT: begin
          // Row count and long-column count by repeated subtraction.
          rows_r <= rows_r + CW'(1);
          if ((CW+1)'(rem_r) > (CW+1)'(job_r.cols)) begin
            rem_r <= CW'((CW+1)'(rem_r) - (CW+1)'(job_r.cols));
          end else begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= mem[{job_r.bank, idx_r[AW-1:0]}];
            out_last_r  <= is_final;
            empty_r     <= 1'b0;
            ovf_r       <= job_r.ovf;
            sent_r      <= sent_r + CW'(1);
            if (is_final) begin
              state_r <= ST_IDLE;
            end
            if (job_r.mode == MODE_ENC) begin
              if (enc_step >= (CW+1)'(job_r.n)) begin
                col_r <= col_r + RODS_W'(1);
                idx_r <= (CW+1)'(col_r) + (CW+1)'(1);
              end else begin
                idx_r <= enc_step;
              end
            end else begin
              if (col_r == job_r.cols - RODS_W'(1)) begin
                col_r <= '0;
                row_r <= row_r + CW'(1);
                idx_r <= (CW+1)'(row_r) + (CW+1)'(1);
              end else begin
                col_r <= col_r + RODS_W'(1);
                idx_r <= dec_step;
              end
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= '0;
            out_last_r  <= 1'b1;
            empty_r     <= 1'b1;
            ovf_r       <= job_r.ovf;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/scytale_transposition.sv
// Scytale transposition top level: front loader, job queue and read-out sequencer.
//
//   port    dir  beat carries                               when taken
//   in_ch   in   in_char, in_last                           valid && ready
//   out_ch  out  out_char, out_last, empty_res, overflow    valid && ready
//   cfg_ch  in   index (0 mode, 1 rods), data               valid && ready
//
// Loading takes one byte per cycle, unless stalled, into one of two 64-byte buffer
// banks. After the last byte, encryption emits one character per cycle while
// out_ch is ready; decryption does the row split first, then emits at that rate.
// The front keeps loading the next message while the back emits the previous one;
// it stalls only when both banks hold messages not yet read out.
// Reset is synchronous; the buffer needs no clearing pass.
module scytale_transposition
  import scy_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  scy_in_if.sink    in_ch,
  scy_out_if.source out_ch,
  scy_cfg_if.sink   cfg_ch
);

  job_t       front_job;
  job_t       head_job;
  buf_wr_t    buf_wr;
  logic       job_push;
  logic       job_pop;
  logic       job_valid;
  logic       job_full;
  logic [1:0] job_count;
  logic       back_busy;
  logic [2:0] in_flight;
  logic       hold;

  assign in_flight = {1'b0, job_count} + {2'b00, back_busy};
  assign hold      = (in_flight >= 3'd2);

  scy_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .hold     (hold),
    .job_full (job_full),
    .job_push (job_push),
    .job      (front_job),
    .buf_wr   (buf_wr)
  );

  scy_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (front_job),
    .pop       (job_pop),
    .head      (head_job),
    .not_empty (job_valid),
    .full      (job_full),
    .count     (job_count)
  );

  scy_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_wr    (buf_wr),
    .job_valid (job_valid),
    .job_in    (head_job),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .out_ch    (out_ch)
  );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the scytale transposition block with a cycle-free message predictor.
`timescale 1ns / 100ps

module tb_top;
  import scy_pkg::*;

  typedef enum logic [1:0] {ACT_BYTE, ACT_WRITE, ACT_SYNC} act_kind_t;

  typedef struct {
    act_kind_t             kind;
    logic [CHAR_W-1:0]     chr;
    logic                  fin;
    logic [CFG_IX_W-1:0]   ix;
    logic [RODS_W-1:0]     val;
  } act_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              fin;
    logic              empty;
    logic              ovf;
  } cipher_t;

  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 80;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scy_in_if  in_ch();
  scy_out_if out_ch();
  scy_cfg_if cfg_ch();

  scytale_transposition dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  act_t    stim_q[$];
  cipher_t cipher_q[$];
  int      bytes_queued = 0;
  int      mismatches   = 0;
  bit      stim_done    = 1'b0;

  // Predictor state: message being collected plus the register copies.
  logic [CHAR_W-1:0] msg_buf [MAX_LEN];
  int                msg_len  = 0;
  logic              msg_ovf  = 1'b0;
  logic              cur_mode = MODE_ENC;
  logic [RODS_W-1:0] cur_rods = 7'd1;

  function automatic void push_cipher(logic [CHAR_W-1:0] c, logic f, logic e, logic o);
    cipher_t x;
    x.chr   = c;
    x.fin   = f;
    x.empty = e;
    x.ovf   = o;
    cipher_q.push_back(x);
  endfunction

  function automatic void scytale_absorb(logic [CHAR_W-1:0] ch_in, logic fin);
    logic [CHAR_W-1:0] ch;
    bit keep;
    int n, cols, rows, nlong, cnt, idx, len, start;
    ch = ch_in;
    if (cur_mode == MODE_ENC) begin
      if (ch >= "a" && ch <= "z") begin
        ch   = ch - 8'd32;
        keep = 1'b1;
      end else begin
        keep = (ch >= "A" && ch <= "Z");
      end
    end else begin
      keep = (ch != 8'd0);
    end
    if (keep) begin
      if (msg_len < MAX_LEN) begin
        msg_buf[msg_len] = ch;
        msg_len++;
      end else begin
        msg_ovf = 1'b1;
      end
    end
    if (!fin) return;
    n = msg_len;
    if (n == 0) begin
      push_cipher(8'd0, 1'b1, 1'b1, msg_ovf);
    end else begin
      cols = (cur_rods == 0) ? 1 : int'(cur_rods);
      rows = (n + cols - 1) / cols;
      cnt  = 0;
      if (cur_mode == MODE_ENC) begin
        for (int c = 0; c < cols; c++) begin
          for (int r = 0; r < rows; r++) begin
            idx = r * cols + c;
            if (idx < n) begin
              push_cipher(msg_buf[idx], cnt + 1 == n, 1'b0, msg_ovf);
              cnt++;
            end
          end
        end
      end else begin
        // The first n mod cols columns hold one extra row; all of them when it divides.
        nlong = n % cols;
        if (nlong == 0) nlong = cols;
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            len = (c < nlong) ? rows : rows - 1;
            if (r < len) begin
              start = c * (rows - 1) + ((c < nlong) ? c : nlong);
              idx   = start + r;
              if (idx < n) begin
                push_cipher(msg_buf[idx], cnt + 1 == n, 1'b0, msg_ovf);
                cnt++;
              end
            end
          end
        end
      end
    end
    msg_len = 0;
    msg_ovf = 1'b0;
  endfunction

  function automatic void push_byte(logic [CHAR_W-1:0] ch, logic fin);
    act_t a;
    a.kind = ACT_BYTE;
    a.chr  = ch;
    a.fin  = fin;
    a.ix   = CFG_MODE;
    a.val  = '0;
    stim_q.push_back(a);
    bytes_queued++;
  endfunction

  function automatic void push_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], fin && (i == s.len() - 1));
  endfunction

  // Register writes always wait for the block to drain first.
  function automatic void push_write(logic [CFG_IX_W-1:0] ix, int val);
    act_t a;
    a.kind = ACT_SYNC;
    a.chr  = '0;
    a.fin  = 1'b0;
    a.ix   = ix;
    a.val  = RODS_W'(val);
    stim_q.push_back(a);
    a.kind = ACT_WRITE;
    stim_q.push_back(a);
  endfunction

  // Mostly bytes the current mode keeps, with some raw noise; dense messages keep everything.
  function automatic void push_random_msg(int len, logic mode, bit dense);
    logic [CHAR_W-1:0] ch;
    for (int i = 0; i < len; i++) begin
      if (dense || $urandom_range(0, 3) != 0) begin
        if (mode == MODE_ENC)
          ch = ($urandom_range(0, 1) ? "a" : "A") + CHAR_W'($urandom_range(0, 25));
        else
          ch = CHAR_W'($urandom_range(1, 255));
      end else begin
        ch = CHAR_W'($urandom_range(0, 255));
      end
      push_byte(ch, i == len - 1);
    end
  endfunction

  // Sender: presents input and register beats, updates the predictor on acceptance.
  int  gap_left    = 0;
  int  settle_left = 0;
  bit  syncing     = 1'b0;
  bit  send_calm   = 1'b0;

  always @(posedge clk) begin : drive_beats
    act_t a;
    logic v_in, v_cfg;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_char <= '0;
      in_ch.in_last <= 1'b0;
      cfg_ch.valid  <= 1'b0;
      cfg_ch.index  <= CFG_MODE;
      cfg_ch.data   <= '0;
    end else begin
      v_in  = in_ch.valid;
      v_cfg = cfg_ch.valid;
      if (v_in && in_ch.ready) begin
        scytale_absorb(in_ch.in_char, in_ch.in_last);
        v_in = 1'b0;
        if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
        gap_left = send_calm ? 0 : $urandom_range(0, 4);
      end
      if (v_cfg && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_MODE) cur_mode = cfg_ch.data[0];
        else if (cfg_ch.index == CFG_RODS) cur_rods = cfg_ch.data;
        v_cfg = 1'b0;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (!v_in && !v_cfg) begin
        if (syncing) begin
          if (cipher_q.size() == 0) begin
            if (settle_left == 0) syncing = 1'b0;
            else settle_left--;
          end
        end else if (stim_q.size() != 0) begin
          a = stim_q.pop_front();
          case (a.kind)
            ACT_BYTE: begin
              v_in = 1'b1;
              in_ch.in_char <= a.chr;
              in_ch.in_last <= a.fin;
            end
            ACT_WRITE: begin
              v_cfg = 1'b1;
              cfg_ch.index <= a.ix;
              cfg_ch.data  <= a.val;
            end
            default: begin
              syncing     = 1'b1;
              settle_left = SETTLE_CYCLES;
            end
          endcase
        end
      end
      in_ch.valid  <= v_in;
      cfg_ch.valid <= v_cfg;
      stim_done = (stim_q.size() == 0) && !v_in && !v_cfg && !syncing;
    end
  end

  // Receiver: random back-pressure and comparison against the oldest prediction.
  int stall_left = 0;
  bit sink_calm  = 1'b0;

  always @(posedge clk) begin : check_beats
    cipher_t want;
    cipher_t got;
    logic r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      r = out_ch.ready;
      if (out_ch.valid && r) begin
        got.chr   = out_ch.out_char;
        got.fin   = out_ch.out_last;
        got.empty = out_ch.empty_res;
        got.ovf   = out_ch.overflow;
        if (cipher_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat char=%02h last=%b empty=%b ovf=%b",
                     $realtime, got.chr, got.fin, got.empty, got.ovf);
          mismatches++;
        end else begin
          want = cipher_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: char %02h/%02h last %b/%b empty %b/%b ovf %b/%b (exp/act)",
                       $realtime, want.chr, got.chr, want.fin, got.fin,
                       want.empty, got.empty, want.ovf, got.ovf);
            mismatches++;
          end
        end
        if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        r = 1'b0;
      end else begin
        r = 1'b1;
      end
      out_ch.ready <= r;
    end
  end

  initial begin
    int   first_rand, len, phase;
    logic mode;

    // Letter boundaries, lower-case folding and a top byte that encryption drops.
    push_write(CFG_MODE, MODE_ENC);
    push_write(CFG_RODS, 4);
    push_text("aZ@[", 0);
    push_byte(8'h60, 1'b0);
    push_text("{zA", 0);
    push_byte(8'hFF, 1'b1);
    // No letters at all gives the single empty beat.
    push_text("7!", 1);
    // A rod count of zero behaves as one column.
    push_write(CFG_RODS, 0);
    push_text("Abc", 1);
    // Decryption keeps every nonzero byte and drops zeros.
    push_write(CFG_MODE, MODE_DEC);
    push_write(CFG_RODS, 3);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_text("x", 0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h00, 1'b1);
    // Mode switched in the middle of a message.
    push_write(CFG_MODE, MODE_ENC);
    push_text("q1", 0);
    push_write(CFG_MODE, MODE_DEC);
    push_text("2%", 1);
    // More rods than characters: the text passes through.
    push_write(CFG_RODS, 127);
    push_text("Hi!", 1);

    first_rand = bytes_queued;
    phase = 0;
    while (bytes_queued - first_rand < 160) begin
      mode = $urandom_range(0, 1) ? MODE_DEC : MODE_ENC;
      push_write(CFG_MODE, mode);
      if (phase == 0) push_write(CFG_RODS, 64);
      else if (phase == 1) push_write(CFG_RODS, 1);
      else
        case ($urandom_range(0, 5))
          0:       push_write(CFG_RODS, 1);
          1:       push_write(CFG_RODS, 64);
          2:       push_write(CFG_RODS, $urandom_range(33, 64));
          default: push_write(CFG_RODS, $urandom_range(2, 9));
        endcase
      for (int m = $urandom_range(2, 5); m > 0; m--) begin
        // The first phase overruns the buffer once; long messages stay rare.
        if (phase == 0 && m == 1) begin
          push_random_msg($urandom_range(66, 70), mode, 1'b1);
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 16);
          push_random_msg(len, mode, 1'b0);
        end
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (!stim_done || cipher_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && cipher_q.size() == 0)
      $display("scytale_transposition regression: pass");
    else
      $display("scytale_transposition regression: fail");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("scytale_transposition regression: fail");
    $finish;
  end

endmodule
